// File: rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

    // keypad and code register widths
    localparam int KEYS_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int CODE_W      = 20;
    localparam int CODE_DIGITS = CODE_W / DIGIT_W;

    // default code length and register reset (keys 1,2,3,4,5 in scan indices)
    localparam int               DEFAULT_CODE_LENGTH = 5;
    localparam logic [CODE_W-1:0] CODE_RESET         = 20'h51840;

    // scan index of the '#' key
    localparam logic [DIGIT_W-1:0] HASH_INDEX = 4'd11;

    typedef logic [KEYS_W-1:0]  keys_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [DIGIT_W-1:0] digit_t;

endpackage : kcl_pkg

`default_nettype wire

// File: rtl/core/kcl_if.sv
`timescale 1ns / 1ps
`default_nettype none

// keypad scan tick channel
interface kcl_key_if;
    logic                 valid;
    logic                 ready;
    kcl_pkg::keys_t       keys_down;
    logic                 lock_button;

    modport source (output valid, output keys_down, output lock_button, input ready);
    modport sink   (input valid, input keys_down, input lock_button, output ready);
endinterface : kcl_key_if

// lock state result channel
interface kcl_lock_if;
    logic valid;
    logic ready;
    logic locked;

    modport source (output valid, output locked, input ready);
    modport sink   (input valid, input locked, output ready);
endinterface : kcl_lock_if

// code register write channel
interface kcl_cfg_if;
    logic           valid;
    logic           ready;
    kcl_pkg::code_t code_keys;

    modport source (output valid, output code_keys, input ready);
    modport sink   (input valid, input code_keys, output ready);
endinterface : kcl_cfg_if

`default_nettype wire

// File: rtl/core/keypad_code_lock_top.sv
`timescale 1ns / 1ps
`default_nettype none

// keypad code lock
// key_in carries one scan tick per transaction: the 16 key-down lines and the
// lock button. lock_out returns one transaction per tick with the locked flag
// after that tick. cfg writes the 20-bit code register (one key index per
// nibble, first digit lowest); it is always ready. The user must write it only
// while no tick is in flight; the block itself does not enforce this.
// path: lock_out valid follows key_in acceptance through the input register,
// which loads at acceptance, and then the result register, which the state
// update loads.
// throughput: one tick per cycle unless lock_out stalls; the entry and button
// state machines update in one pass of combinational logic, so nothing iterates.
// reset: locked is engaged, both machines go to their start phase, the code
// register takes its default. The first tick only leaves the start phases.
// stall: when lock_out is not taken the result holds, the input register
// still takes one more tick, then key_in drops ready until lock_out drains.
module keypad_code_lock_top #(
    parameter int CODE_LENGTH = kcl_pkg::DEFAULT_CODE_LENGTH
) (
    input  wire       clk,
    input  wire       rst_n,
    kcl_key_if.sink   key_in,
    kcl_lock_if.source lock_out,
    kcl_cfg_if.sink   cfg
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam logic [CNT_W-1:0] CODE_LEN_CNT = CNT_W'(CODE_LENGTH);

    typedef enum logic [2:0] {
        PH_START, PH_WAIT, PH_ARMED, PH_READY, PH_HELD
    } entry_phase_t;

    typedef enum logic [1:0] {
        BT_START, BT_RELEASED, BT_HELD
    } button_phase_t;

    // input register
    logic          in_valid_reg;
    keys_t         keys_reg;
    logic          button_reg;

    // state
    code_t         code_reg;
    entry_phase_t  entry_reg,   entry_next;
    button_phase_t button_ph_reg, button_next;
    logic [CNT_W-1:0] entered_reg, entered_next;
    logic [CNT_W-1:0] matched_reg, matched_next;
    logic          engaged_reg, engaged_next;
    logic          out_valid_reg;

    // handshake
    logic          advance;
    logic          key_any;
    digit_t        key_idx;
    logic          key_hash;
    digit_t        code_digit;

    assign advance      = in_valid_reg && (!out_valid_reg || lock_out.ready);
    assign key_in.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign lock_out.valid  = out_valid_reg;
    assign lock_out.locked = engaged_reg;

    // priority decode: lowest set line wins
    always_comb
    begin
        key_any = 1'b0;
        key_idx = '0;
        for (int i = KEYS_W - 1; i >= 0; i--)
        begin
            if (keys_reg[i])
            begin
                key_any = 1'b1;
                key_idx = DIGIT_W'(i);
            end
        end
    end

    assign key_hash = key_any && (key_idx == HASH_INDEX);

    // code digit at the current position, zero beyond the register
    always_comb
    begin
        code_digit = '0;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (int'(entered_reg) == i)
            begin
                code_digit = code_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // entry and button machines, one tick
    always_comb
    begin
        entry_next   = entry_reg;
        entered_next = entered_reg;
        matched_next = matched_reg;
        engaged_next = engaged_reg;
        button_next  = button_ph_reg;

        case (entry_reg)
            PH_START:
            begin
                entered_next = '0;
                entry_next   = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (key_hash)
                begin
                    entered_next = '0;
                    matched_next = '0;
                    entry_next   = PH_ARMED;
                end
            end
            PH_ARMED:
            begin
                if (!key_any)
                begin
                    entry_next = PH_READY;
                end
            end
            PH_READY:
            begin
                if (key_hash)
                begin
                    entered_next = '0;
                    matched_next = '0;
                    entry_next   = PH_ARMED;
                end
                else if (entered_reg < CODE_LEN_CNT)
                begin
                    if (key_any)
                    begin
                        if (key_idx == code_digit)
                        begin
                            matched_next = matched_reg + CNT_W'(1);
                        end
                        entered_next = entered_reg + CNT_W'(1);
                        entry_next   = PH_HELD;
                    end
                end
                else if (!key_any)
                begin
                    entry_next = PH_WAIT;
                end
            end
            PH_HELD:
            begin
                if (!key_any)
                begin
                    entry_next = PH_READY;
                end
            end
            default:
            begin
            end
        endcase

        // unlock on a full match once back in waiting; clear the counts when re-armed
        if (entry_next == PH_WAIT)
        begin
            if (matched_next == CODE_LEN_CNT)
            begin
                engaged_next = 1'b0;
                matched_next = '0;
            end
        end
        else if (entry_next == PH_ARMED)
        begin
            matched_next = '0;
            entered_next = '0;
        end

        // lock button press edge wins over the keypad
        case (button_ph_reg)
            BT_START:
            begin
                button_next = BT_RELEASED;
            end
            BT_RELEASED:
            begin
                if (button_reg)
                begin
                    engaged_next = 1'b1;
                    button_next  = BT_HELD;
                end
            end
            BT_HELD:
            begin
                if (!button_reg)
                begin
                    button_next = BT_RELEASED;
                end
            end
            default:
            begin
            end
        endcase
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
        begin
            keys_reg   <= key_in.keys_down;
            button_reg <= key_in.lock_button;
        end
    end

    // state, result and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            code_reg      <= CODE_RESET;
            entry_reg     <= PH_START;
            button_ph_reg <= BT_START;
            entered_reg   <= '0;
            matched_reg   <= '0;
            engaged_reg   <= 1'b1;
        end
        else
        begin
            if (key_in.ready)
            begin
                in_valid_reg <= key_in.valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                entry_reg     <= entry_next;
                button_ph_reg <= button_next;
                entered_reg   <= entered_next;
                matched_reg   <= matched_next;
                engaged_reg   <= engaged_next;
            end
            else if (lock_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                code_reg <= cfg.code_keys;
            end
        end
    end

endmodule : keypad_code_lock_top

`default_nettype wire
